@@ hw/rtl/click_grid_histogram_core_assert.svh @@
// Assertion macros of the click grid histogram port checker.
// Depends on nothing; included by the checker file.
`ifndef CLICK_GRID_HISTOGRAM_CORE_ASSERT_SVH
`define CLICK_GRID_HISTOGRAM_CORE_ASSERT_SVH

// Same-cycle implication under reset.
`define CGH_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset.
`define CGH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/cgh_pkg.sv @@
// Shared types, codes and constants of the click grid histogram.
// Depends on nothing; imported by every module of the block.
package cgh_pkg;

    // Default values of the top-level parameters.
    localparam int DEF_MAX_ROWS    = 16;
    localparam int DEF_MAX_COLUMNS = 16;
    localparam int DEF_COORD_BITS  = 16;

    // Fixed field widths.
    localparam int SIZE_BITS     = 16;
    localparam int GRID_CFG_BITS = 5;
    localparam int COUNT_BITS    = 16;
    localparam int BYTE_BITS     = 8;
    localparam int CELL_BITS     = 4;
    localparam int IN_DATA_W     = 16;
    localparam int OUT_DATA_W    = 40;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 16;

    // Character codes of the click log.
    localparam logic [BYTE_BITS-1:0] CHAR_ZERO    = 8'd48;
    localparam logic [BYTE_BITS-1:0] CHAR_NINE    = CHAR_ZERO + 8'd9;
    localparam logic [BYTE_BITS-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [BYTE_BITS-1:0] CHAR_COMMA   = 8'd44;

    localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = 16'hFFFF;

    // Register reset values.
    localparam logic [SIZE_BITS-1:0]     RST_CELL_WIDTH   = 16'd192;
    localparam logic [SIZE_BITS-1:0]     RST_CELL_HEIGHT  = 16'd108;
    localparam logic [GRID_CFG_BITS-1:0] RST_GRID_COLUMNS = 5'd10;
    localparam logic [GRID_CFG_BITS-1:0] RST_GRID_ROWS    = 5'd10;

    // Input action and reply kind codes.
    localparam logic ACTION_TEXT = 1'b0;
    localparam logic ACTION_READ = 1'b1;
    localparam logic KIND_BIN    = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CELL_WIDTH,
        REG_CELL_HEIGHT,
        REG_GRID_COLUMNS,
        REG_GRID_ROWS
    } cfg_index_t;

    // Control sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIVIDE,
        ST_FETCH,
        ST_EMIT
    } state_t;

    // Request strobes into the count store.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

endpackage

@@ hw/rtl/cgh_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on cgh_pkg; used twice by the top level for the two coordinates.
module cgh_div #(
    parameter int COORD_BITS = cgh_pkg::DEF_COORD_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [COORD_BITS-1:0]          dividend,
    input  logic [cgh_pkg::SIZE_BITS-1:0]  divisor,
    output logic                           done,
    output logic [COORD_BITS-1:0]          quotient
);
    import cgh_pkg::*;

    localparam int CNT_W = $clog2(COORD_BITS + 1);

    logic [COORD_BITS-1:0] quo_reg;
    logic [SIZE_BITS-1:0]  rem_reg;
    logic [SIZE_BITS-1:0]  dsr_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  done_reg;
    logic [SIZE_BITS:0]    shifted;
    logic [SIZE_BITS:0]    diff;
    logic                  ge;

    // One trial subtraction. A zero divisor always succeeds, so the quotient is all ones.
    assign shifted = {rem_reg, quo_reg[COORD_BITS-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign ge      = (shifted >= {1'b0, dsr_reg});

    // Step counter and completion strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(COORD_BITS);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? diff[SIZE_BITS-1:0] : shifted[SIZE_BITS-1:0];
            quo_reg <= {quo_reg[COORD_BITS-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ hw/rtl/cgh_store.sv @@
// Count store: one synchronous memory with a registered read port.
// Depends on cgh_pkg; clears itself after reset, one entry per cycle.
module cgh_store #(
    parameter int DEPTH  = cgh_pkg::DEF_MAX_ROWS * cgh_pkg::DEF_MAX_COLUMNS,
    parameter int ADDR_W = $clog2(cgh_pkg::DEF_MAX_ROWS * cgh_pkg::DEF_MAX_COLUMNS)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cgh_pkg::mem_ctl_t              ctl,
    input  logic [ADDR_W-1:0]              rd_addr,
    input  logic [ADDR_W-1:0]              wr_addr,
    input  logic [cgh_pkg::COUNT_BITS-1:0] wr_data,
    output logic [cgh_pkg::COUNT_BITS-1:0] rd_data,
    output logic                           busy
);
    import cgh_pkg::*;

    logic [COUNT_BITS-1:0] mem [DEPTH];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic [ADDR_W-1:0]     clear_addr_reg;
    logic                  clear_busy_reg;

    // Clearing sweep after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_addr_reg <= '0;
            clear_busy_reg <= 1'b1;
        end
        else if (clear_busy_reg)
        begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
            if (clear_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clear_busy_reg <= 1'b0;
            end
        end
    end

    // Write port, shared by the sweep and the count update.
    always_ff @(posedge clk)
    begin
        if (clear_busy_reg)
        begin
            mem[clear_addr_reg] <= '0;
        end
        else if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clear_busy_reg;

endmodule

@@ hw/rtl/click_grid_histogram_core.sv @@
// Click grid histogram: parses "x,y" text lines and counts clicks per grid cell.
// It also answers cell reads. A non-newline text byte leaves the sequencer idle and ready.
// A read goes through the fetch and emit states; a newline first runs the two restoring
// dividers, one bit per cycle. Each count update is a read, then a write of the count
// memory; one item is in flight. After reset the count memory is swept to zero,
// during which no item is accepted; configuration writes are taken at any time.
module click_grid_histogram_core #(
    parameter int MAX_ROWS    = cgh_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = cgh_pkg::DEF_MAX_COLUMNS,
    parameter int COORD_BITS  = cgh_pkg::DEF_COORD_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // text_byte [7:0], read_row [11:8], read_column [15:12]
    input  logic [cgh_pkg::IN_DATA_W-1:0]   s_tdata,
    // action [0]
    input  logic                            s_tuser,
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // cell_row [3:0], cell_column [7:4], cell_count [23:8], max_count [39:24]
    output logic [cgh_pkg::OUT_DATA_W-1:0]  m_tdata,
    // reply_kind [0]
    output logic                            m_tuser,
    // Configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cgh_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cgh_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import cgh_pkg::*;

    localparam int DEPTH   = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int LIM_R_W = $clog2(MAX_ROWS + 1);
    localparam int LIM_C_W = $clog2(MAX_COLUMNS + 1);

    // Configuration registers
    logic [SIZE_BITS-1:0]     cell_width_reg;
    logic [SIZE_BITS-1:0]     cell_height_reg;
    logic [GRID_CFG_BITS-1:0] grid_columns_reg;
    logic [GRID_CFG_BITS-1:0] grid_rows_reg;

    // Parser state
    logic [COORD_BITS-1:0] x_acc_reg;
    logic [COORD_BITS-1:0] y_acc_reg;
    logic                  after_comma_reg;
    logic [COUNT_BITS-1:0] max_reg;

    // Item in flight
    state_t                state_reg;
    state_t                state_next;
    logic                  kind_reg;
    logic [CELL_BITS-1:0]  row_reg;
    logic [CELL_BITS-1:0]  col_reg;
    logic                  oob_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [COUNT_BITS-1:0] count_reg;

    // Output register
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic                  m_tuser_reg;

    // Decoded input and internal strobes
    logic                  in_fire;
    logic [BYTE_BITS-1:0]  text_byte;
    logic [CELL_BITS-1:0]  read_row;
    logic [CELL_BITS-1:0]  read_column;
    logic                  is_digit;
    logic                  is_comma;
    logic                  is_newline;
    logic [3:0]            digit;
    logic [COORD_BITS-1:0] acc_sel;
    logic [COORD_BITS-1:0] acc_times_ten;
    logic                  read_oob;
    logic [ADDR_W-1:0]     read_addr;
    logic                  div_start;
    logic                  x_done;
    logic                  y_done;
    logic [COORD_BITS-1:0] x_quot;
    logic [COORD_BITS-1:0] y_quot;
    logic [LIM_C_W-1:0]    lim_c;
    logic [LIM_R_W-1:0]    lim_r;
    logic [COL_W-1:0]      bin_col;
    logic [ROW_W-1:0]      bin_row;
    logic [ADDR_W-1:0]     bin_addr;
    mem_ctl_t              mem_ctl;
    logic [ADDR_W-1:0]     mem_rd_addr;
    logic [COUNT_BITS-1:0] mem_rd_data;
    logic [COUNT_BITS-1:0] inc_count;
    logic                  store_busy;
    logic                  out_free;
    logic                  out_load;

    // Field extraction
    assign in_fire     = s_tvalid && s_tready;
    assign text_byte   = s_tdata[7:0];
    assign read_row    = s_tdata[11:8];
    assign read_column = s_tdata[15:12];
    assign is_digit    = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
    assign is_comma    = (text_byte == CHAR_COMMA);
    assign is_newline  = (text_byte == CHAR_NEWLINE);
    assign digit       = 4'(text_byte - CHAR_ZERO);

    // Decimal accumulation: acc * 10 + digit, wrapping at COORD_BITS.
    assign acc_sel       = after_comma_reg ? y_acc_reg : x_acc_reg;
    assign acc_times_ten = (acc_sel << 3) + (acc_sel << 1) + COORD_BITS'(digit);

    // Address of a read request; entries beyond the store reply with zero.
    assign read_oob  = (32'(read_row) >= MAX_ROWS) || (32'(read_column) >= MAX_COLUMNS);
    assign read_addr = ADDR_W'(read_row) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(read_column);

    // Grid size in use: zero counts as one, and the store size caps it.
    assign lim_c = (grid_columns_reg == '0) ? LIM_C_W'(1) :
                   (32'(grid_columns_reg) > MAX_COLUMNS) ? LIM_C_W'(MAX_COLUMNS) :
                   LIM_C_W'(grid_columns_reg);
    assign lim_r = (grid_rows_reg == '0) ? LIM_R_W'(1) :
                   (32'(grid_rows_reg) > MAX_ROWS) ? LIM_R_W'(MAX_ROWS) :
                   LIM_R_W'(grid_rows_reg);

    // Clamp the quotients to the last column and row.
    assign bin_col = ({{LIM_C_W{1'b0}}, x_quot} >= {{COORD_BITS{1'b0}}, lim_c}) ?
                     COL_W'(lim_c - 1'b1) : COL_W'(x_quot);
    assign bin_row = ({{LIM_R_W{1'b0}}, y_quot} >= {{COORD_BITS{1'b0}}, lim_r}) ?
                     ROW_W'(lim_r - 1'b1) : ROW_W'(y_quot);
    assign bin_addr = ADDR_W'(bin_row) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(bin_col);

    // Saturating increment of the fetched count.
    assign inc_count = (mem_rd_data == COUNT_LIMIT) ? mem_rd_data : mem_rd_data + 1'b1;

    assign out_free = !m_tvalid_reg || m_tready;

    // Coordinate dividers
    cgh_div #(
        .COORD_BITS(COORD_BITS)
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (x_acc_reg),
        .divisor  (cell_width_reg),
        .done     (x_done),
        .quotient (x_quot)
    );

    cgh_div #(
        .COORD_BITS(COORD_BITS)
    ) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (y_acc_reg),
        .divisor  (cell_height_reg),
        .done     (y_done),
        .quotient (y_quot)
    );

    // Count memory
    cgh_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mem_ctl),
        .rd_addr (mem_rd_addr),
        .wr_addr (addr_reg),
        .wr_data (inc_count),
        .rd_data (mem_rd_data),
        .busy    (store_busy)
    );

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (!store_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_tuser == ACTION_READ)
                    begin
                        state_next = ST_FETCH;
                    end
                    else if (is_newline)
                    begin
                        state_next = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (x_done && y_done)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // State-decoded outputs and strobes
    always_comb
    begin
        s_tready      = 1'b0;
        div_start     = 1'b0;
        mem_ctl.rd_en = 1'b0;
        mem_ctl.wr_en = 1'b0;
        mem_rd_addr   = read_addr;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
            end
            ST_IDLE:
            begin
                s_tready      = 1'b1;
                div_start     = in_fire && (s_tuser == ACTION_TEXT) && is_newline;
                mem_ctl.rd_en = in_fire && (s_tuser == ACTION_READ);
            end
            ST_DIVIDE:
            begin
                mem_ctl.rd_en = x_done && y_done;
                mem_rd_addr   = bin_addr;
            end
            ST_FETCH:
            begin
                mem_ctl.wr_en = (kind_reg == KIND_BIN);
            end
            ST_EMIT:
            begin
                out_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration registers, writable at any time.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_width_reg   <= RST_CELL_WIDTH;
            cell_height_reg  <= RST_CELL_HEIGHT;
            grid_columns_reg <= RST_GRID_COLUMNS;
            grid_rows_reg    <= RST_GRID_ROWS;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_CELL_WIDTH:   cell_width_reg   <= cfg_data;
                REG_CELL_HEIGHT:  cell_height_reg  <= cfg_data;
                REG_GRID_COLUMNS: grid_columns_reg <= cfg_data[GRID_CFG_BITS-1:0];
                REG_GRID_ROWS:    grid_rows_reg    <= cfg_data[GRID_CFG_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Text parser: digits build x, then y after a comma; a newline starts over.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_acc_reg       <= '0;
            y_acc_reg       <= '0;
            after_comma_reg <= 1'b0;
        end
        else if (in_fire && (s_tuser == ACTION_TEXT))
        begin
            if (is_digit)
            begin
                if (after_comma_reg)
                begin
                    y_acc_reg <= acc_times_ten;
                end
                else
                begin
                    x_acc_reg <= acc_times_ten;
                end
            end
            else if (is_comma)
            begin
                after_comma_reg <= 1'b1;
            end
            else if (is_newline)
            begin
                x_acc_reg       <= '0;
                y_acc_reg       <= '0;
                after_comma_reg <= 1'b0;
            end
        end
    end

    // Cell and address of the item in flight.
    always_ff @(posedge clk)
    begin
        if (in_fire && (s_tuser == ACTION_READ))
        begin
            kind_reg <= KIND_READ;
            row_reg  <= read_row;
            col_reg  <= read_column;
            oob_reg  <= read_oob;
        end
        else if (in_fire && is_newline)
        begin
            kind_reg <= KIND_BIN;
        end
        else if ((state_reg == ST_DIVIDE) && x_done && y_done)
        begin
            row_reg  <= CELL_BITS'(bin_row);
            col_reg  <= CELL_BITS'(bin_col);
            oob_reg  <= 1'b0;
            addr_reg <= bin_addr;
        end
    end

    // Fetched or updated count.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FETCH)
        begin
            if (kind_reg == KIND_BIN)
            begin
                count_reg <= inc_count;
            end
            else
            begin
                count_reg <= oob_reg ? '0 : mem_rd_data;
            end
        end
    end

    // Running maximum over all cell counts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= '0;
        end
        else if ((state_reg == ST_FETCH) && (kind_reg == KIND_BIN) && (inc_count > max_reg))
        begin
            max_reg <= inc_count;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= {max_reg, count_reg, col_reg, row_reg};
            m_tuser_reg <= kind_reg;
        end
    end

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign cfg_ready = 1'b1;

endmodule

@@ hw/rtl/cgh_port_checker.sv @@
// Port-level checks of the click grid histogram core, bound to the top level.
// Depends on cgh_pkg and click_grid_histogram_core_assert.svh.
`include "click_grid_histogram_core_assert.svh"

module cgh_port_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [cgh_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           m_tuser
);
    import cgh_pkg::*;

    // A stalled result keeps its payload.
    `CGH_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // No cell count may exceed the running maximum.
    `CGH_ASSERT_IMPLIES(a_count_le_max, clk, rst_n, m_tvalid, m_tdata[23:8] <= m_tdata[39:24], "cell count above maximum")

    // A binned click always leaves a nonzero count.
    `CGH_ASSERT_IMPLIES(a_bin_nonzero, clk, rst_n, m_tvalid && (m_tuser == KIND_BIN), m_tdata[23:8] != 16'd0, "binned count is zero")

    // A read request occupies the store, so the input stalls in the next cycle.
    `CGH_ASSERT_NEXT(a_read_stalls, clk, rst_n, s_tvalid && s_tready && (s_tuser == ACTION_READ), !s_tready, "input taken during read")

endmodule

bind click_grid_histogram_core cgh_port_checker u_port_checker (.*);

@@ tb/testbench.sv @@
// Self-checking testbench of the click grid histogram core.
// Depends on cgh_pkg and click_grid_histogram_core; drives random text and reads
// with random idling on both streams and checks every reply against its own model.
`timescale 1ns / 1ps

module testbench;
    import cgh_pkg::*;

    localparam int ROWS_MAX      = DEF_MAX_ROWS;
    localparam int COLUMNS_MAX   = DEF_MAX_COLUMNS;
    localparam int SETTLE_CYCLES = DEF_COORD_BITS + 8;
    localparam int RANDOM_ITEMS  = 650;
    localparam int PHASES        = 5;

    // One reply of the block, as the model predicts it.
    typedef struct {
        logic                  kind;
        logic [CELL_BITS-1:0]  row;
        logic [CELL_BITS-1:0]  column;
        logic [COUNT_BITS-1:0] count;
        logic [COUNT_BITS-1:0] peak;
    } reply_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Histogram model: registers, line parser and count store.
    logic [SIZE_BITS-1:0]     cell_w;
    logic [SIZE_BITS-1:0]     cell_h;
    logic [GRID_CFG_BITS-1:0] grid_cols;
    logic [GRID_CFG_BITS-1:0] grid_rows;
    logic [DEF_COORD_BITS-1:0] x_pos;
    logic [DEF_COORD_BITS-1:0] y_pos;
    bit                        in_y;
    logic [COUNT_BITS-1:0]     tally [ROWS_MAX*COLUMNS_MAX];
    logic [COUNT_BITS-1:0]     peak_tally;

    reply_t pending_replies [$];
    int     mismatches;
    int     counted_requests;
    bit     src_idle_on;
    bit     sink_idle_on;
    int     sink_hold;

    click_grid_histogram_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Overall time limit of the run.
    initial
    begin
        #(64'd80_000_000);
        $display("testbench NOT OK");
        $finish;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Grid size in use: zero counts as one, oversize counts as the maximum.
    function automatic int used_cells(logic [GRID_CFG_BITS-1:0] cfg, int maximum);
        if (cfg == 0)
            return 1;
        if (cfg > maximum)
            return maximum;
        return cfg;
    endfunction

    // Column or row of a coordinate, clamped to the last one in use.
    function automatic logic [CELL_BITS-1:0] cell_of(logic [DEF_COORD_BITS-1:0] coord,
                                                     logic [SIZE_BITS-1:0] size, int lim);
        longint unsigned q;
        q = (size == 0) ? 64'hFFFF_FFFF : coord / size;
        if (q >= lim)
            q = lim - 1;
        return q[CELL_BITS-1:0];
    endfunction

    function automatic bit is_digit(logic [BYTE_BITS-1:0] b);
        return b >= CHAR_ZERO && b <= CHAR_NINE;
    endfunction

    function void flag_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // Advance the model by one accepted request and queue its reply, if any.
    task automatic apply_request(logic action, logic [BYTE_BITS-1:0] b,
                                 logic [CELL_BITS-1:0] row, logic [CELL_BITS-1:0] col);
        reply_t r;
        logic [COUNT_BITS-1:0] cnt;
        if (action == ACTION_READ)
        begin
            r.kind   = KIND_READ;
            r.row    = row;
            r.column = col;
            r.count  = tally[{row, col}];
            r.peak   = peak_tally;
            pending_replies.push_back(r);
        end
        else if (is_digit(b))
        begin
            if (in_y)
                y_pos = y_pos * 10 + (b - CHAR_ZERO);
            else
                x_pos = x_pos * 10 + (b - CHAR_ZERO);
        end
        else if (b == CHAR_COMMA)
        begin
            in_y = 1'b1;
        end
        else if (b == CHAR_NEWLINE)
        begin
            r.kind   = KIND_BIN;
            r.column = cell_of(x_pos, cell_w, used_cells(grid_cols, COLUMNS_MAX));
            r.row    = cell_of(y_pos, cell_h, used_cells(grid_rows, ROWS_MAX));
            cnt = tally[{r.row, r.column}];
            if (cnt != COUNT_LIMIT)
                cnt++;
            tally[{r.row, r.column}] = cnt;
            if (cnt > peak_tally)
                peak_tally = cnt;
            r.count = cnt;
            r.peak  = peak_tally;
            pending_replies.push_back(r);
            x_pos = '0;
            y_pos = '0;
            in_y  = 1'b0;
        end
    endtask

    // Offer one request on the input stream and wait until it is taken.
    task automatic send_request(logic action, logic [BYTE_BITS-1:0] b,
                                logic [CELL_BITS-1:0] row, logic [CELL_BITS-1:0] col);
        int gap;
        gap = src_idle_on ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = action;
        s_tdata  = {col, row, b};
        do
            @(posedge clk);
        while (!s_tready);
        if (action == ACTION_READ || is_digit(b) || b == CHAR_COMMA || b == CHAR_NEWLINE)
            counted_requests++;
        apply_request(action, b, row, col);
    endtask

    task automatic send_byte(logic [BYTE_BITS-1:0] b);
        send_request(ACTION_TEXT, b, $urandom, $urandom);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_read(logic [CELL_BITS-1:0] row, logic [CELL_BITS-1:0] col);
        send_request(ACTION_READ, $urandom, row, col);
    endtask

    // Lower the input request, wait for every reply, then let the block settle.
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_CELL_WIDTH:   cell_w    = value;
            REG_CELL_HEIGHT:  cell_h    = value;
            REG_GRID_COLUMNS: grid_cols = value[GRID_CFG_BITS-1:0];
            REG_GRID_ROWS:    grid_rows = value[GRID_CFG_BITS-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_grid(logic [15:0] w, logic [15:0] h, logic [15:0] cols,
                              logic [15:0] rows);
        write_register(REG_CELL_WIDTH, w);
        write_register(REG_CELL_HEIGHT, h);
        write_register(REG_GRID_COLUMNS, cols);
        write_register(REG_GRID_ROWS, rows);
    endtask

    // Coordinate that mostly lands inside the grid, sometimes just past it.
    function automatic int pick_coord(logic [SIZE_BITS-1:0] size, int lim);
        longint span;
        span = longint'(size) * lim;
        if (size == 0 || span > 60000)
            return $urandom_range(0, 65535);
        return $urandom_range(0, int'(span + span / 8));
    endfunction

    task automatic send_number(int v);
        string s;
        s = $sformatf("%0d", v);
        if ($urandom_range(0, 9) == 0)
            s = {"0", s};
        send_text(s);
    endtask

    // One random sequence: mostly well-formed lines, plus reads, noise and broken lines.
    task automatic send_random_sequence();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            send_number(pick_coord(cell_w, used_cells(grid_cols, COLUMNS_MAX)));
            send_byte(CHAR_COMMA);
            send_number(pick_coord(cell_h, used_cells(grid_rows, ROWS_MAX)));
            send_byte(CHAR_NEWLINE);
        end
        else if (r < 72)
        begin
            if ($urandom_range(0, 1) == 0)
                send_read($urandom_range(0, used_cells(grid_rows, ROWS_MAX) - 1),
                          $urandom_range(0, used_cells(grid_cols, COLUMNS_MAX) - 1));
            else
                send_read($urandom, $urandom);
        end
        else if (r < 80)
        begin
            send_byte($urandom_range(0, 255));
        end
        else if (r < 88)
        begin
            case ($urandom_range(0, 3))
                0: send_text("\n");
                1: send_text(",\n");
                2: send_text($sformatf("%0d\n", $urandom_range(0, 9999)));
                default: send_text($sformatf("%0d,,%0d\n", $urandom_range(0, 999),
                                             $urandom_range(0, 999)));
            endcase
        end
        else if (r < 94)
        begin
            // Long digit runs make both coordinates wrap.
            send_text($sformatf("%0d,%0d\n", $urandom_range(65536, 99_999_999),
                                $urandom_range(65536, 99_999_999)));
        end
        else
        begin
            send_text($sformatf(" %0d ,\t%0d\r\n", pick_coord(cell_w, 16),
                                pick_coord(cell_h, 16)));
        end
    endtask

    // Extremes of the fields, every action, and the parser's corner cases.
    task automatic test_directed_text();
        send_text("\n");
        send_byte(8'hFF);
        send_byte("a");
        send_text("99999\n");
        send_text("5,,7\n");
        // A read in the middle of a line leaves the parser alone.
        send_text("3,");
        send_read(4'd0, 4'd0);
        send_text("9\n");
        send_read(4'd15, 4'd15);
        send_read(4'd0, 4'd0);
        wait_drained();
    endtask

    // Zero cell sizes and grid sizes outside the allowed range.
    task automatic test_config_extremes();
        write_grid(16'd0, 16'd0, 16'd0, 16'd31);
        send_text("12,34\n");
        send_text("\n");
        wait_drained();
        write_grid(16'hFFFF, 16'hFFFF, 16'd17, 16'd16);
        send_text("65535,65535\n");
        send_read(4'd15, 4'd0);
        wait_drained();
    endtask

    // The receiver holds off while lines keep coming, so the block backs up.
    task automatic test_output_holdoff();
        write_grid(16'd8, 16'd8, 16'd16, 16'd16);
        src_idle_on = 1'b0;
        sink_hold   = 400;
        for (int i = 0; i < 12; i++)
        begin
            send_text($sformatf("%0d,%0d\n", $urandom_range(0, 140), $urandom_range(0, 140)));
            send_read($urandom, $urandom);
        end
        wait_drained();
    endtask

    // Random traffic over several register settings.
    task automatic test_random_phases();
        int goal;
        int next_toggle;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: write_grid(16'd1, 16'd1, 16'd16, 16'd16);
                1: write_grid(16'd100, 16'd50, 16'd7, 16'd3);
                2: write_grid(16'hFFFF, 16'd1, 16'd1, 16'd16);
                3: write_grid($urandom_range(1, 4000), $urandom_range(1, 4000),
                              $urandom_range(1, 16), $urandom_range(1, 16));
                default: write_grid(16'd30, 16'hFFFF, 16'd31, 16'd17);
            endcase
            goal = counted_requests + RANDOM_ITEMS / PHASES;
            next_toggle = counted_requests + 50;
            while (counted_requests < goal)
            begin
                send_random_sequence();
                if (counted_requests >= next_toggle)
                begin
                    src_idle_on  = $urandom_range(0, 3) != 0;
                    sink_idle_on = $urandom_range(0, 3) != 0;
                    next_toggle  = counted_requests + 50;
                    // Now and then the sender waits for every reply.
                    if ($urandom_range(0, 2) == 0)
                        wait_drained();
                end
            end
            wait_drained();
        end
    endtask

    // Drive one cell to the count limit; the count and the maximum must stay there.
    task automatic test_saturation();
        write_grid(RST_CELL_WIDTH, RST_CELL_HEIGHT, RST_GRID_COLUMNS, RST_GRID_ROWS);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        while (tally[0] != COUNT_LIMIT)
            send_byte(CHAR_NEWLINE);
        send_text("\n\n");
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        send_read(4'd0, 4'd0);
        send_read(4'd15, 4'd15);
        send_text("1900,1000\n");
        wait_drained();
    endtask

    // Receiver side: random stalls, plus a long hold when a test asks for one.
    initial
    begin
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold > 0)
            begin
                m_tready = 1'b0;
                sink_hold--;
            end
            else if (stall > 0)
            begin
                m_tready = 1'b0;
                stall--;
            end
            else
            begin
                m_tready = 1'b1;
                if (sink_idle_on)
                    stall = pick_gap();
            end
        end
    end

    // Compare every reply taken with the oldest prediction.
    always @(posedge clk)
    begin : check_replies
        reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_replies.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected reply kind=%0d data=%h", m_tuser, m_tdata));
            end
            else
            begin
                want = pending_replies.pop_front();
                if (m_tuser !== want.kind || m_tdata[3:0] !== want.row ||
                    m_tdata[7:4] !== want.column || m_tdata[23:8] !== want.count ||
                    m_tdata[39:24] !== want.peak)
                    flag_mismatch($sformatf(
                        "reply mismatch: want kind=%0d row=%0d col=%0d count=%0d max=%0d, got kind=%0d row=%0d col=%0d count=%0d max=%0d",
                        want.kind, want.row, want.column, want.count, want.peak,
                        m_tuser, m_tdata[3:0], m_tdata[7:4], m_tdata[23:8], m_tdata[39:24]));
            end
        end
    end

    // Reset, then the tests in turn.
    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = ACTION_TEXT;
        cfg_valid = 1'b0;
        cfg_index = REG_CELL_WIDTH;
        cfg_data  = '0;
        mismatches       = 0;
        counted_requests = 0;
        src_idle_on      = 1'b1;
        sink_idle_on     = 1'b1;
        sink_hold        = 0;
        cell_w     = RST_CELL_WIDTH;
        cell_h     = RST_CELL_HEIGHT;
        grid_cols  = RST_GRID_COLUMNS;
        grid_rows  = RST_GRID_ROWS;
        x_pos      = '0;
        y_pos      = '0;
        in_y       = 1'b0;
        peak_tally = '0;
        foreach (tally[i])
            tally[i] = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_text();
        test_config_extremes();
        test_output_holdoff();
        test_random_phases();
        test_saturation();

        wait_drained();
        if (mismatches == 0 && pending_replies.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
